// ===== hw/rtl/esp_pkg.sv =====
// Shared types and constants for the elapsed-sleep prior reweighting block.
package esp_pkg;

  localparam int NSTAGE = 5;
  localparam int VAL_W  = 16;
  localparam int PROD_W = 32;
  localparam int SUM_W  = 35;
  localparam int NUM_W  = 48;
  localparam int Q_W    = 16;
  localparam int BIN_OUT_W = 6;

  // Item command codes.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_EPOCH = 1'b1;

  typedef logic [VAL_W-1:0]  val_t;
  typedef logic [PROD_W-1:0] prod_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [NUM_W-1:0]  num_t;
  typedef logic [Q_W-1:0]    quot_t;

  typedef struct packed {
    logic start;
    num_t num;
    sum_t den;
  } div_req_t;

  typedef struct packed {
    logic  done;
    quot_t quot;
  } div_rsp_t;

endpackage

// ===== hw/rtl/esp_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module esp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/esp_div.sv =====
// Restoring divider, one quotient bit per cycle, for the renormalizing step.
module esp_div (
  input  logic              clk,
  input  logic              rst_n,
  input  esp_pkg::div_req_t req,
  output esp_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(esp_pkg::Q_W + 1);

  esp_pkg::sum_t  rem_r;
  esp_pkg::sum_t  den_r;
  esp_pkg::quot_t low_r;
  esp_pkg::quot_t q_r;
  logic [CNT_W-1:0] cnt_r;
  logic busy_r;
  logic done_r;

  logic [esp_pkg::SUM_W:0] shifted;
  logic [esp_pkg::SUM_W:0] diff;
  logic                    fits;

  // The high half of the numerator is already below the divisor, so only
  // the low sixteen bits are brought down.
  assign shifted = {rem_r, low_r[esp_pkg::Q_W-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign fits    = (shifted >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(esp_pkg::Q_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= esp_pkg::SUM_W'(req.num[esp_pkg::NUM_W-1:esp_pkg::Q_W]);
      low_r <= req.num[esp_pkg::Q_W-1:0];
      den_r <= req.den;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? diff[esp_pkg::SUM_W-1:0] : shifted[esp_pkg::SUM_W-1:0];
      low_r <= {low_r[esp_pkg::Q_W-2:0], 1'b0};
      q_r   <= {q_r[esp_pkg::Q_W-2:0], fits};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule

// ===== hw/rtl/elapsed_sleep_prior_reweight.sv =====
// Elapsed-sleep prior reweighting of five sleep-stage posteriors per epoch.
// A load item writes one bin start and five priors; an epoch reads its bin start, then
// for each stage a prior and its product, then divides each product in turn by the sum.
// One item at a time; the shared 16-step divider, used once per stage unless the sum is
// zero, bounds the epoch rate. A finished result waits in the output register.
// Reset (rst_n, synchronous, active low) clears the count, bin, bins_in_use (to 1)
// and control; the bin start and prior memories hold nothing until loaded.
module elapsed_sleep_prior_reweight #(
  parameter int MAX_BINS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: bins_in_use
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,
  // Input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [5:0]  in_bin_index,
  input  logic [15:0] in_bin_start,
  input  logic [15:0] in_value_n1,
  input  logic [15:0] in_value_n2,
  input  logic [15:0] in_value_n3,
  input  logic [15:0] in_value_rem,
  input  logic [15:0] in_value_wake,
  input  logic        in_is_wake,
  input  logic        in_first_epoch,
  // Result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_post_n1,
  output logic [15:0] out_post_n2,
  output logic [15:0] out_post_n3,
  output logic [15:0] out_post_rem,
  output logic [15:0] out_post_wake,
  output logic        out_sum_was_zero,
  output logic [5:0]  out_bin_used
);

  // Bin index width, width of the bin-count arithmetic and prior address width.
  localparam int BIN_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int NB_W  = $clog2(MAX_BINS + 1);
  localparam int CW    = ((NB_W > 7) ? NB_W : 7) + 1;
  localparam int PDEPTH = MAX_BINS * esp_pkg::NSTAGE;
  localparam int PA_W  = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
  localparam logic [CW-1:0] MAXB = CW'(MAX_BINS);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOAD = 4'd1;
  localparam logic [3:0] S_BIN  = 4'd2;
  localparam logic [3:0] S_THR  = 4'd3;
  localparam logic [3:0] S_RD   = 4'd4;
  localparam logic [3:0] S_MUL  = 4'd5;
  localparam logic [3:0] S_ACC  = 4'd6;
  localparam logic [3:0] S_NUM  = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  localparam logic [2:0] K_LAST = 3'(esp_pkg::NSTAGE - 1);

  // Control state.
  logic [3:0]       state_r;
  logic [3:0]       state_nxt;
  logic [2:0]       k_r;
  logic [2:0]       k_nxt;
  logic [6:0]       bins_in_use_r;
  logic [15:0]      count_r;
  logic [BIN_W-1:0] bin_r;
  logic             adv_ok_r;
  logic             out_valid_r;

  // Captured item and work registers.
  logic [5:0]       idx_r;
  logic [15:0]      start_r;
  esp_pkg::val_t    val_r [esp_pkg::NSTAGE];
  logic             is_wake_r;
  logic             first_r;
  esp_pkg::prod_t   prod_r [esp_pkg::NSTAGE];
  esp_pkg::sum_t    sum_r;
  esp_pkg::quot_t   quot_r [esp_pkg::NSTAGE];

  // Output registers.
  esp_pkg::val_t    post_r [esp_pkg::NSTAGE];
  logic             zero_r;
  logic [5:0]       bin_used_r;

  logic in_xfer;
  logic out_xfer;
  logic out_load;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid_r && out_ready;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);

  // Effective bin count: zero acts as one, anything above MAX_BINS as MAX_BINS.
  logic [CW-1:0] cfg_ext;
  logic [CW-1:0] nb;
  logic [CW-1:0] bin_first;
  logic [CW-1:0] bin_cl;
  logic [CW-1:0] bin_nx;

  assign cfg_ext = CW'(bins_in_use_r);
  assign nb = (cfg_ext == '0) ? CW'(1) : ((cfg_ext > MAXB) ? MAXB : cfg_ext);

  // A first epoch restarts from bin zero; a bin beyond the count in use is
  // pulled back to the last bin in use before the advance check.
  assign bin_first = first_r ? '0 : CW'(bin_r);
  assign bin_cl    = (bin_first >= nb) ? (nb - CW'(1)) : bin_first;
  assign bin_nx    = bin_cl + CW'(1);

  // Load items beyond the table depth are dropped.
  logic idx_ok;
  assign idx_ok = (CW'(idx_r) < MAXB);

  // Bin start memory.
  logic             thr_we;
  logic [BIN_W-1:0] thr_raddr;
  logic [15:0]      thr_rdata;

  assign thr_we    = (state_r == S_LOAD) && (k_r == 3'd0) && idx_ok;
  assign thr_raddr = BIN_W'(bin_nx);

  esp_ram #(
    .WIDTH (16),
    .DEPTH (MAX_BINS)
  ) u_thr_ram (
    .clk   (clk),
    .we    (thr_we),
    .waddr (BIN_W'(idx_r)),
    .wdata (start_r),
    .raddr (thr_raddr),
    .rdata (thr_rdata)
  );

  // Prior memory: five consecutive entries per bin, one per stage.
  logic          pri_we;
  logic [PA_W-1:0] pri_waddr;
  logic [PA_W-1:0] pri_raddr;
  esp_pkg::val_t pri_rdata;

  assign pri_we    = (state_r == S_LOAD) && idx_ok;
  assign pri_waddr = (PA_W'(idx_r) << 2) + PA_W'(idx_r) + PA_W'(k_r);
  assign pri_raddr = (PA_W'(bin_r) << 2) + PA_W'(bin_r) + PA_W'(k_r);

  esp_ram #(
    .WIDTH (esp_pkg::VAL_W),
    .DEPTH (PDEPTH)
  ) u_pri_ram (
    .clk   (clk),
    .we    (pri_we),
    .waddr (pri_waddr),
    .wdata (val_r[k_r]),
    .raddr (pri_raddr),
    .rdata (pri_rdata)
  );

  // Weighted posterior of the current stage.
  esp_pkg::prod_t mul_w;
  assign mul_w = {16'b0, val_r[k_r]} * {16'b0, pri_rdata};

  // Numerator prod * 65535, formed as prod * 65536 - prod.
  esp_pkg::num_t num_w;
  assign num_w = {prod_r[k_r], 16'b0} - esp_pkg::NUM_W'(prod_r[k_r]);

  esp_pkg::div_req_t div_req;
  esp_pkg::div_rsp_t div_rsp;

  assign div_req.start = (state_r == S_NUM) && (sum_r != '0);
  assign div_req.num   = num_w;
  assign div_req.den   = sum_r;

  esp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    unique case (state_r)
      S_IDLE: begin
        k_nxt = 3'd0;
        if (in_xfer) begin
          state_nxt = (in_command == esp_pkg::CMD_LOAD) ? S_LOAD : S_BIN;
        end
      end
      S_LOAD: begin
        if (k_r == K_LAST) begin
          state_nxt = S_IDLE;
        end else begin
          k_nxt = k_r + 3'd1;
        end
      end
      S_BIN: begin
        state_nxt = S_THR;
      end
      S_THR: begin
        state_nxt = S_RD;
        k_nxt     = 3'd0;
      end
      S_RD: begin
        state_nxt = S_MUL;
      end
      S_MUL: begin
        state_nxt = S_ACC;
      end
      S_ACC: begin
        if (k_r == K_LAST) begin
          state_nxt = S_NUM;
          k_nxt     = 3'd0;
        end else begin
          state_nxt = S_RD;
          k_nxt     = k_r + 3'd1;
        end
      end
      S_NUM: begin
        state_nxt = (sum_r == '0) ? S_OUT : S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          if (k_r == K_LAST) begin
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_NUM;
            k_nxt     = k_r + 3'd1;
          end
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        k_nxt     = 3'd0;
      end
    endcase
  end

  // Control registers, including the elapsed count and current bin.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      k_r           <= 3'd0;
      bins_in_use_r <= 7'd1;
      count_r       <= '0;
      bin_r         <= '0;
      adv_ok_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      if (cfg_wr_en) begin
        bins_in_use_r <= cfg_wr_data;
      end
      if (state_r == S_BIN) begin
        bin_r    <= BIN_W'(bin_cl);
        adv_ok_r <= (bin_nx < nb);
        if (first_r) begin
          count_r <= '0;
        end
      end
      // The count is compared before this epoch adds to it, and saturates.
      if (state_r == S_THR) begin
        if (adv_ok_r && (count_r >= thr_rdata)) begin
          bin_r <= bin_r + BIN_W'(1);
        end
        if (!is_wake_r && (count_r != 16'hFFFF)) begin
          count_r <= count_r + 16'd1;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item capture and datapath registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      idx_r     <= in_bin_index;
      start_r   <= in_bin_start;
      val_r[0]  <= in_value_n1;
      val_r[1]  <= in_value_n2;
      val_r[2]  <= in_value_n3;
      val_r[3]  <= in_value_rem;
      val_r[4]  <= in_value_wake;
      is_wake_r <= in_is_wake;
      first_r   <= in_first_epoch;
    end
    if (state_r == S_THR) begin
      sum_r <= '0;
    end
    if (state_r == S_MUL) begin
      prod_r[k_r] <= mul_w;
    end
    if (state_r == S_ACC) begin
      sum_r <= sum_r + esp_pkg::SUM_W'(prod_r[k_r]);
    end
    if ((state_r == S_DIV) && div_rsp.done) begin
      quot_r[k_r] <= div_rsp.quot;
    end
    // A zero weighted sum forces all five posts to zero.
    if (out_load) begin
      for (int i = 0; i < esp_pkg::NSTAGE; i++) begin
        post_r[i] <= (sum_r == '0) ? '0 : quot_r[i];
      end
      zero_r     <= (sum_r == '0);
      bin_used_r <= 6'(bin_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_post_n1      = post_r[0];
  assign out_post_n2      = post_r[1];
  assign out_post_n3      = post_r[2];
  assign out_post_rem     = post_r[3];
  assign out_post_wake    = post_r[4];
  assign out_sum_was_zero = zero_r;
  assign out_bin_used     = bin_used_r;

endmodule

// ===== hw/rtl/esp_checker.sv =====
// Port-level checks for the elapsed-sleep prior reweighting block, with its bind.
module esp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_post_n1,
  input logic [15:0] out_post_n2,
  input logic [15:0] out_post_n3,
  input logic [15:0] out_post_rem,
  input logic [15:0] out_post_wake,
  input logic        out_sum_was_zero,
  input logic [5:0]  out_bin_used
);

  // A result stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_post_n1) && $stable(out_post_n2) &&
      $stable(out_post_n3) && $stable(out_post_rem) && $stable(out_post_wake) &&
      $stable(out_sum_was_zero) && $stable(out_bin_used))
    else $error("stalled result changed");

  // A zero weighted sum gives all-zero posts.
  a_zero_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sum_was_zero |-> (out_post_n1 == 16'd0) &&
      (out_post_n2 == 16'd0) && (out_post_n3 == 16'd0) &&
      (out_post_rem == 16'd0) && (out_post_wake == 16'd0))
    else $error("nonzero post with zero weighted sum");

  // Items are worked one at a time: a transfer closes the input channel.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  // Reset empties the result register.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind elapsed_sleep_prior_reweight esp_checker u_esp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_post_n1      (out_post_n1),
  .out_post_n2      (out_post_n2),
  .out_post_n3      (out_post_n3),
  .out_post_rem     (out_post_rem),
  .out_post_wake    (out_post_wake),
  .out_sum_was_zero (out_sum_was_zero),
  .out_bin_used     (out_bin_used)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the elapsed-sleep prior reweighting block.
`timescale 1ns / 1ps

module tb_top;

  localparam int NBINS  = 64;
  // Cycles allowed after the last expected result before the block counts as idle.
  localparam int SETTLE = 200;
  // Watchdog limit; the slowest correct run stays far below it.
  localparam int unsigned LIMIT = 2_000_000;
  // Number of random items given to each configuration phase.
  localparam int PHASE_ITEMS = 115;
  localparam int NPHASE = 10;

  // One input transfer: a load command or an epoch, stage order N1, N2, N3, REM, wake.
  typedef struct packed {
    logic                                  command;
    logic [5:0]                            bin_index;
    esp_pkg::val_t                         bin_start;
    esp_pkg::val_t [esp_pkg::NSTAGE-1:0]   val;
    logic                                  is_wake;
    logic                                  first_epoch;
  } item_t;

  // One result transfer.
  typedef struct packed {
    esp_pkg::val_t [esp_pkg::NSTAGE-1:0]   post;
    logic                                  sum_was_zero;
    logic [5:0]                            bin_used;
  } post_t;

  // Scoreboard: keeps its own copy of the tables, the sleep count and the
  // current bin, and queues the revised posteriors each epoch should give.
  class reweight_board;
    esp_pkg::val_t start_mem [NBINS];
    esp_pkg::val_t prior_mem [NBINS][esp_pkg::NSTAGE];
    logic [15:0]   sleep_count;
    int unsigned   cur_bin;
    logic [6:0]    bins_reg;
    post_t         expected_posts [$];
    int            errors;
    int            results_seen;
    string         stage_name [esp_pkg::NSTAGE] = '{"post_n1", "post_n2", "post_n3",
                                                    "post_rem", "post_wake"};

    function new();
      foreach (start_mem[i]) start_mem[i] = '0;
      foreach (prior_mem[i, k]) prior_mem[i][k] = '0;
      sleep_count  = '0;
      cur_bin      = 0;
      bins_reg     = 7'd1;
      errors       = 0;
      results_seen = 0;
    endfunction

    function void write_bins_reg(logic [6:0] v);
      bins_reg = v;
    endfunction

    // Called for every accepted input transfer.
    function void take_item(item_t it);
      int unsigned nb;
      logic [63:0] prod [esp_pkg::NSTAGE];
      logic [63:0] sum;
      post_t       want;
      if (it.command == esp_pkg::CMD_LOAD) begin
        start_mem[it.bin_index] = it.bin_start;
        for (int k = 0; k < esp_pkg::NSTAGE; k++) prior_mem[it.bin_index][k] = it.val[k];
        return;
      end
      if (it.first_epoch) begin
        sleep_count = '0;
        cur_bin     = 0;
      end
      if (bins_reg == 0) nb = 1;
      else if (bins_reg > NBINS) nb = NBINS;
      else nb = bins_reg;
      if (cur_bin >= nb) cur_bin = nb - 1;
      // The count is compared before this epoch adds to it.
      if (cur_bin + 1 < nb && sleep_count >= start_mem[cur_bin + 1]) cur_bin++;
      sum = '0;
      for (int k = 0; k < esp_pkg::NSTAGE; k++) begin
        prod[k] = 64'(it.val[k]) * 64'(prior_mem[cur_bin][k]);
        sum += prod[k];
      end
      for (int k = 0; k < esp_pkg::NSTAGE; k++) begin
        if (sum == 0) want.post[k] = '0;
        else want.post[k] = 16'((prod[k] * 64'd65535) / sum);
      end
      want.sum_was_zero = (sum == 0);
      want.bin_used     = 6'(cur_bin);
      expected_posts = {expected_posts, want};
      if (!it.is_wake && sleep_count != 16'hFFFF) sleep_count++;
    endfunction

    function void report(string field, int unsigned want, int unsigned got);
      errors++;
      if (errors <= 40)
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
    endfunction

    // Called for every accepted result transfer.
    function void check_posts(post_t got);
      post_t want;
      results_seen++;
      if (expected_posts.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: result with nothing expected, actual posts %h flag %b bin %0d",
                   $time, got.post, got.sum_was_zero, got.bin_used);
        return;
      end
      want = expected_posts.pop_front();
      for (int k = 0; k < esp_pkg::NSTAGE; k++)
        if (got.post[k] !== want.post[k]) report(stage_name[k], want.post[k], got.post[k]);
      if (got.sum_was_zero !== want.sum_was_zero)
        report("sum_was_zero", want.sum_was_zero, got.sum_was_zero);
      if (got.bin_used !== want.bin_used) report("bin_used", want.bin_used, got.bin_used);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [6:0]  cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic        in_command;
  logic [5:0]  in_bin_index;
  logic [15:0] in_bin_start;
  logic [15:0] in_value_n1;
  logic [15:0] in_value_n2;
  logic [15:0] in_value_n3;
  logic [15:0] in_value_rem;
  logic [15:0] in_value_wake;
  logic        in_is_wake;
  logic        in_first_epoch;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_post_n1;
  logic [15:0] out_post_n2;
  logic [15:0] out_post_n3;
  logic [15:0] out_post_rem;
  logic [15:0] out_post_wake;
  logic        out_sum_was_zero;
  logic [5:0]  out_bin_used;

  reweight_board board;
  item_t         mon_item;
  post_t         mon_post;
  int unsigned   cycles = 0;
  bit            no_gap_mode = 1'b0;
  int            calm_left = 0;
  bit            held_off = 1'b0;

  elapsed_sleep_prior_reweight #(.MAX_BINS(NBINS)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_bin_index     (in_bin_index),
    .in_bin_start     (in_bin_start),
    .in_value_n1      (in_value_n1),
    .in_value_n2      (in_value_n2),
    .in_value_n3      (in_value_n3),
    .in_value_rem     (in_value_rem),
    .in_value_wake    (in_value_wake),
    .in_is_wake       (in_is_wake),
    .in_first_epoch   (in_first_epoch),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_post_n1      (out_post_n1),
    .out_post_n2      (out_post_n2),
    .out_post_n3      (out_post_n3),
    .out_post_rem     (out_post_rem),
    .out_post_wake    (out_post_wake),
    .out_sum_was_zero (out_sum_was_zero),
    .out_bin_used     (out_bin_used)
  );

  always #6 clk = ~clk;

  // Watchdog: a run that hangs ends here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Monitor. Everything is sampled at the rising edge, so the values seen are
  // the ones the block saw at that edge, and all three kinds of transfer are
  // handed to the scoreboard from this one place.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) board.write_bins_reg(cfg_wr_data);
      if (in_valid && in_ready) begin
        mon_item.command     = in_command;
        mon_item.bin_index   = in_bin_index;
        mon_item.bin_start   = in_bin_start;
        mon_item.val[0]      = in_value_n1;
        mon_item.val[1]      = in_value_n2;
        mon_item.val[2]      = in_value_n3;
        mon_item.val[3]      = in_value_rem;
        mon_item.val[4]      = in_value_wake;
        mon_item.is_wake     = in_is_wake;
        mon_item.first_epoch = in_first_epoch;
        board.take_item(mon_item);
      end
      if (out_valid && out_ready) begin
        mon_post.post[0]      = out_post_n1;
        mon_post.post[1]      = out_post_n2;
        mon_post.post[2]      = out_post_n3;
        mon_post.post[3]      = out_post_rem;
        mon_post.post[4]      = out_post_wake;
        mon_post.sum_was_zero = out_sum_was_zero;
        mon_post.bin_used     = out_bin_used;
        board.check_posts(mon_post);
      end
    end
  end

  // Posterior values lean toward zero and full scale so that zero sums and
  // extreme products come up often.
  function automatic esp_pkg::val_t rand_post();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return 16'hFFFF;
    if (r == 2) return esp_pkg::val_t'($urandom_range(0, 15));
    return esp_pkg::val_t'($urandom);
  endfunction

  function automatic esp_pkg::val_t rand_prior();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r < 2) return '0;
    if (r == 2) return 16'hFFFF;
    return esp_pkg::val_t'($urandom);
  endfunction

  // Fields that a command does not use are still random so every bit toggles.
  function automatic item_t make_load(logic [5:0] idx, esp_pkg::val_t start);
    item_t it;
    it.command     = esp_pkg::CMD_LOAD;
    it.bin_index   = idx;
    it.bin_start   = start;
    for (int k = 0; k < esp_pkg::NSTAGE; k++) it.val[k] = rand_prior();
    it.is_wake     = 1'($urandom);
    it.first_epoch = 1'($urandom);
    return it;
  endfunction

  function automatic item_t make_epoch(logic first, logic wake);
    item_t it;
    it.command     = esp_pkg::CMD_EPOCH;
    it.bin_index   = 6'($urandom);
    it.bin_start   = esp_pkg::val_t'($urandom);
    for (int k = 0; k < esp_pkg::NSTAGE; k++) it.val[k] = rand_post();
    it.is_wake     = wake;
    it.first_epoch = first;
    return it;
  endfunction

  // Sender gaps: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int unsigned r;
    if (no_gap_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // Receiver stalls, with occasional calm runs where it never stalls.
  function automatic int pick_stall();
    int unsigned r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) calm_left = 40;
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  // Offers one item and returns once it has been transferred. Valid is only
  // dropped when a gap follows, so back-to-back items keep it high.
  task automatic send_item(input item_t it);
    int gap;
    in_valid       <= 1'b1;
    in_command     <= it.command;
    in_bin_index   <= it.bin_index;
    in_bin_start   <= it.bin_start;
    in_value_n1    <= it.val[0];
    in_value_n2    <= it.val[1];
    in_value_n3    <= it.val[2];
    in_value_rem   <= it.val[3];
    in_value_wake  <= it.val[4];
    in_is_wake     <= it.is_wake;
    in_first_epoch <= it.first_epoch;
    do @(posedge clk); while (!in_ready);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering, waits for every expected result and then lets the block
  // settle, since a load leaves no result to wait for.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.expected_posts.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_bins(input logic [6:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Extremes of the fields, one stage at a time, zero sums from both sides,
  // wake epochs and a night restart. Only bin 0 is in use here.
  task automatic run_directed();
    item_t it;
    it = make_load(6'd0, 16'd0);
    it.val = {esp_pkg::NSTAGE{16'hFFFF}};
    send_item(it);
    it = make_epoch(1'b1, 1'b0);
    it.val = {esp_pkg::NSTAGE{16'hFFFF}};
    send_item(it);
    // All posteriors zero gives a zero weighted sum.
    it = make_epoch(1'b0, 1'b0);
    it.val = '0;
    send_item(it);
    for (int s = 0; s < esp_pkg::NSTAGE; s++) begin
      it = make_epoch(1'b0, 1'b0);
      for (int k = 0; k < esp_pkg::NSTAGE; k++) it.val[k] = (k == s) ? 16'hFFFF : 16'h0000;
      send_item(it);
    end
    it = make_epoch(1'b0, 1'b0);
    it.val = '0;
    it.val[0] = 16'd1;
    send_item(it);
    send_item(make_epoch(1'b0, 1'b1));
    // A bin with all priors zero also gives a zero sum.
    it = make_load(6'd0, 16'hFFFF);
    it.val = '0;
    send_item(it);
    it = make_epoch(1'b0, 1'b0);
    it.val = {esp_pkg::NSTAGE{16'hFFFF}};
    send_item(it);
    // Highest bin index, not in use yet.
    send_item(make_load(6'd63, 16'hFFFF));
    it = make_load(6'd0, esp_pkg::val_t'($urandom));
    it.val = {16'h8000, 16'hFFFF, 16'h0000, 16'd1, 16'hFFFF};
    send_item(it);
    it = make_epoch(1'b1, 1'b1);
    it.val = {esp_pkg::NSTAGE{16'hFFFF}};
    send_item(it);
    send_item(make_epoch(1'b0, 1'b0));
  endtask

  // Random part of one phase: mostly whole nights that start with a first
  // epoch, sprinkled with reloads of random bins and the odd restart in the
  // middle of a night.
  task automatic run_nights(input int budget);
    int sent;
    int night_len;
    logic first;
    sent = 0;
    while (sent < budget) begin
      night_len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 90)
                                              : $urandom_range(3, 40);
      for (int j = 0; j < night_len && sent < budget; j++) begin
        if ($urandom_range(0, 19) == 0) begin
          send_item(make_load(6'($urandom), esp_pkg::val_t'($urandom)));
        end else begin
          first = (j == 0) || ($urandom_range(0, 49) == 0);
          send_item(make_epoch(first, $urandom_range(0, 4) == 0));
        end
        sent++;
      end
    end
  endtask

  // Receiver. Once, after a few hundred results, it holds off for a long
  // stretch while the sender keeps offering, so the block fills and stalls
  // its input.
  initial begin
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!held_off && board.results_seen >= 200) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (3000) @(posedge clk);
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        int stall;
        stall = pick_stall();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  // Main sequence: reset, directed items, then phases under different
  // bins_in_use settings. Before a phase raises the number of bins, every
  // bin in use is loaded, so no epoch ever reads an empty table entry.
  initial begin
    logic [6:0]    bins_value;
    int            nb;
    int            step;
    esp_pkg::val_t start;
    rst_n          <= 1'b0;
    cfg_wr_en      <= 1'b0;
    cfg_wr_data    <= '0;
    in_valid       <= 1'b0;
    in_command     <= esp_pkg::CMD_LOAD;
    in_bin_index   <= '0;
    in_bin_start   <= '0;
    in_value_n1    <= '0;
    in_value_n2    <= '0;
    in_value_n3    <= '0;
    in_value_rem   <= '0;
    in_value_wake  <= '0;
    in_is_wake     <= 1'b0;
    in_first_epoch <= 1'b0;
    board = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    for (int ph = 0; ph < NPHASE; ph++) begin
      // The first phases hit the extremes: zero (acts as one), the full
      // table, the top of the register and a single bin.
      case (ph)
        0: bins_value = 7'd0;
        1: bins_value = 7'd64;
        2: bins_value = 7'd127;
        3: bins_value = 7'd1;
        default: begin
          if ($urandom_range(0, 3) == 0) bins_value = 7'($urandom_range(65, 127));
          else bins_value = 7'($urandom_range(1, 64));
        end
      endcase
      if (bins_value == 0) nb = 1;
      else if (bins_value > NBINS) nb = NBINS;
      else nb = bins_value;
      no_gap_mode = (ph % 3 == 2);
      // Bin starts rise in small steps so nights walk deep into the table;
      // one phase uses starts from the whole range instead.
      step = $urandom_range(0, 3);
      for (int k = 0; k < nb; k++) begin
        start = (ph == 5) ? esp_pkg::val_t'($urandom) : esp_pkg::val_t'(k * step);
        send_item(make_load(6'(k), start));
      end
      wait_idle();
      write_bins(bins_value);
      run_nights(PHASE_ITEMS);
    end
    no_gap_mode = 1'b0;

    wait_idle();
    if (board.errors == 0 && board.expected_posts.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
